### hdl/tntf_pkg.sv
// ----------------------------------------------------------------------------
// tntf_pkg
// Types and constants shared by the triangle normal and tangent frame unit.
// ----------------------------------------------------------------------------
package tntf_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int UNIT_WIDTH  = 16;

  // Edge and texcoord differences carry one extra bit.
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int VEC_W  = PROD_W + 2;

  // Normalizer: components are scaled below 2^A_W before the length is taken.
  localparam int A_W         = 30;
  localparam int SUM_W       = 2 * A_W + 2;
  localparam int LEN_W       = A_W + 1;
  localparam int SQRT_STEPS  = SUM_W / 2;
  localparam int SQRT_J_W    = $clog2(SQRT_STEPS);
  localparam int DEN_W       = LEN_W + 1;
  localparam int Q_W         = UNIT_WIDTH;
  localparam int Q_J_W       = $clog2(Q_W);
  localparam int CMP_W       = DEN_W + Q_W;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [VEC_W-1:0]      vec_t;
  typedef logic signed [UNIT_WIDTH-1:0] unit_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] tex_u;
    logic signed [COORD_WIDTH-1:0] tex_v;
    logic signed [UNIT_WIDTH-1:0]  vnorm_x;
    logic signed [UNIT_WIDTH-1:0]  vnorm_y;
    logic signed [UNIT_WIDTH-1:0]  vnorm_z;
  } in_item_t;

  typedef struct packed {
    logic signed [UNIT_WIDTH-1:0] normal_x;
    logic signed [UNIT_WIDTH-1:0] normal_y;
    logic signed [UNIT_WIDTH-1:0] normal_z;
    logic signed [UNIT_WIDTH-1:0] tangent_x;
    logic signed [UNIT_WIDTH-1:0] tangent_y;
    logic signed [UNIT_WIDTH-1:0] tangent_z;
    logic signed [UNIT_WIDTH-1:0] bitangent_x;
    logic signed [UNIT_WIDTH-1:0] bitangent_y;
    logic signed [UNIT_WIDTH-1:0] bitangent_z;
    logic                         normal_fallback;
    logic                         tangent_valid;
  } out_item_t;

  // One face as handed from the front to the back.
  typedef struct packed {
    diff_t [2:0] e1;   // p1 - p0
    diff_t [2:0] e2n;  // p2 - p0
    diff_t [2:0] e2t;  // p2 - p1
    diff_t       du1;
    diff_t       dv1;
    diff_t       du2;
    diff_t       dv2;
    unit_t [2:0] vn;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_NSTART, B_NWAIT, B_DCHK, B_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    P_FACE, P_DET, P_TAN, P_BIT
  } pass_e;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DLOAD, N_DIV
  } norm_state_e;

endpackage

### hdl/triangle_normal_tangent_frame_unit.sv
// ----------------------------------------------------------------------------
// triangle_normal_tangent_frame_unit
// Per-face unit normal, tangent and bitangent from streamed triangle corners.
// ----------------------------------------------------------------------------
// Corners are pushed one per cycle while full is low; every third corner
// closes a face and yields one item with the Q2.14 normal, tangent and
// bitangent plus the fallback and tangent-valid flags. The front takes the
// first two corners of a face at once and holds the third only while the
// two-entry face queue is full. The back's time per face is set by the single
// shared 33x33 multiplier, with up to 20 products, and by up to three passes
// through the serial normalizer. Each pass takes up to 38 one-bit scaling
// steps, a 31-step square root and a 16-step divide per component. A face with
// a zero UV determinant ends after the determinant products, with no
// normalizer pass for the tangent. A finished item waits in the output register
// while the next face is computed.
module triangle_normal_tangent_frame_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  tntf_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output tntf_pkg::out_item_t out_item_o
);
  import tntf_pkg::*;

  job_t job_in, job_out;
  logic job_push, job_full, job_pop, job_empty, res_valid;

  tntf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .item_i     (in_item_i),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  tntf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  tntf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .pop_i       (pop && res_valid),
    .res_valid_o (res_valid),
    .res_o       (out_item_o)
  );

  assign empty = !res_valid;

endmodule

### hdl/tntf_front.sv
// ----------------------------------------------------------------------------
// tntf_front
// Collects corners and forms the edge and texcoord deltas of each face.
// ----------------------------------------------------------------------------
module tntf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  tntf_pkg::in_item_t item_i,
  input  logic               job_full_i,
  output logic               job_push_o,
  output tntf_pkg::job_t     job_o
);
  import tntf_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  in_item_t   c0_q, c1_q;
  logic       third, accept;

  assign third      = (cnt_q >= 2'd2);
  assign full_o     = third && job_full_i;
  assign accept     = push_i && !full_o;
  assign job_push_o = accept && third;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = third ? 2'd0 : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cnt_q == 2'd0) begin
      c0_q <= item_i;
    end
    if (accept && cnt_q == 2'd1) begin
      c1_q <= item_i;
    end
  end

  always_comb begin
    job_o.e1[0]  = DIFF_W'(c1_q.pos_x) - DIFF_W'(c0_q.pos_x);
    job_o.e1[1]  = DIFF_W'(c1_q.pos_y) - DIFF_W'(c0_q.pos_y);
    job_o.e1[2]  = DIFF_W'(c1_q.pos_z) - DIFF_W'(c0_q.pos_z);
    job_o.e2n[0] = DIFF_W'(item_i.pos_x) - DIFF_W'(c0_q.pos_x);
    job_o.e2n[1] = DIFF_W'(item_i.pos_y) - DIFF_W'(c0_q.pos_y);
    job_o.e2n[2] = DIFF_W'(item_i.pos_z) - DIFF_W'(c0_q.pos_z);
    job_o.e2t[0] = DIFF_W'(item_i.pos_x) - DIFF_W'(c1_q.pos_x);
    job_o.e2t[1] = DIFF_W'(item_i.pos_y) - DIFF_W'(c1_q.pos_y);
    job_o.e2t[2] = DIFF_W'(item_i.pos_z) - DIFF_W'(c1_q.pos_z);
    // The v coordinate is flipped to 1-v, which reverses the v deltas.
    job_o.du1    = DIFF_W'(c1_q.tex_u) - DIFF_W'(c0_q.tex_u);
    job_o.dv1    = DIFF_W'(c0_q.tex_v) - DIFF_W'(c1_q.tex_v);
    job_o.du2    = DIFF_W'(item_i.tex_u) - DIFF_W'(c1_q.tex_u);
    job_o.dv2    = DIFF_W'(c1_q.tex_v) - DIFF_W'(item_i.tex_v);
    job_o.vn[0]  = c0_q.vnorm_x;
    job_o.vn[1]  = c0_q.vnorm_y;
    job_o.vn[2]  = c0_q.vnorm_z;
  end

endmodule

### hdl/tntf_fifo.sv
// ----------------------------------------------------------------------------
// tntf_fifo
// Short queue of face jobs between the front and the back.
// ----------------------------------------------------------------------------
module tntf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tntf_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output tntf_pkg::job_t data_o,
  output logic           empty_o
);
  import tntf_pkg::*;

  job_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_AW:0]     count_q;

  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("job queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job popped from empty queue");

endmodule

### hdl/tntf_norm.sv
// ----------------------------------------------------------------------------
// tntf_norm
// Serial vector normalizer: scale, sum of squares, square root, divide.
// ----------------------------------------------------------------------------
module tntf_norm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tntf_pkg::vec_t [2:0]  vec_i,
  output logic                  done_o,
  output logic                  zero_o,
  output tntf_pkg::unit_t [2:0] unit_o
);
  import tntf_pkg::*;

  norm_state_e          state_q, state_d;
  logic [VEC_W-1:0]     mag_q [3];
  logic                 neg_q [3];
  logic [1:0]           sq_idx_q, sq_sel, ci_q;
  logic [2*A_W-1:0]     sq_q;
  logic [SUM_W-1:0]     sum_q, x_q, r_q, bitv, r_next, x_next;
  logic [SUM_W:0]       trial;
  logic                 sqrt_ge;
  logic [SQRT_J_W-1:0]  j_q;
  logic [CMP_W-1:0]     rem_q, dsh, den_ext;
  logic [Q_J_W-1:0]     qj_q;
  logic [Q_W-1:0]       q_q, q_new;
  logic                 div_ge, over, done_q, zero_q;
  logic [VEC_W-1:0]     big_or;
  unit_t                unit_q [3];

  assign big_or = mag_q[0] | mag_q[1] | mag_q[2];
  assign over   = |big_or[VEC_W-1:A_W];
  assign sq_sel = (sq_idx_q == 2'd3) ? 2'd0 : sq_idx_q;

  // One bit of the integer square root per cycle.
  assign bitv    = SUM_W'(1) << {j_q, 1'b0};
  assign trial   = {1'b0, r_q} + {1'b0, bitv};
  assign sqrt_ge = ({1'b0, x_q} >= trial);
  assign x_next  = sqrt_ge ? x_q - trial[SUM_W-1:0] : x_q;
  assign r_next  = sqrt_ge ? (r_q >> 1) + bitv : (r_q >> 1);

  // One quotient bit per cycle against the doubled length.
  assign den_ext = CMP_W'({r_q[LEN_W-1:0], 1'b0});
  assign dsh     = den_ext << qj_q;
  assign div_ge  = (rem_q >= dsh);
  assign q_new   = div_ge ? (q_q | (Q_W'(1) << qj_q)) : q_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      N_IDLE:  if (start_i) state_d = N_SHIFT;
      N_SHIFT: if (!over) state_d = N_SQ;
      N_SQ:    if (sq_idx_q == 2'd3) state_d = N_SQRT;
      N_SQRT: begin
        if (j_q == '0) begin
          state_d = (r_next == '0) ? N_IDLE : N_DLOAD;
        end
      end
      N_DLOAD: state_d = N_DIV;
      N_DIV: begin
        if (qj_q == '0) begin
          state_d = (ci_q == 2'd2) ? N_IDLE : N_DLOAD;
        end
      end
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == N_SQRT) && (j_q == '0) && (r_next == '0)) ||
                 ((state_q == N_DIV) && (qj_q == '0) && (ci_q == 2'd2));
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= vec_i[i][VEC_W-1];
          mag_q[i] <= vec_i[i][VEC_W-1] ? VEC_W'(-$signed(vec_i[i]))
                                        : VEC_W'($signed(vec_i[i]));
        end
      end
      N_SHIFT: begin
        // Truncating shifts compose, so one bit a cycle matches a single shift.
        if (over) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= mag_q[i] >> 1;
          end
        end else begin
          sum_q    <= '0;
          sq_idx_q <= 2'd0;
        end
      end
      N_SQ: begin
        sq_q     <= mag_q[sq_sel][A_W-1:0] * mag_q[sq_sel][A_W-1:0];
        sq_idx_q <= sq_idx_q + 2'd1;
        if (sq_idx_q != 2'd0) begin
          sum_q <= sum_q + SUM_W'(sq_q);
        end
        if (sq_idx_q == 2'd3) begin
          x_q <= sum_q + SUM_W'(sq_q);
          r_q <= '0;
          j_q <= SQRT_J_W'(SQRT_STEPS - 1);
        end
      end
      N_SQRT: begin
        x_q <= x_next;
        r_q <= r_next;
        j_q <= j_q - 1'b1;
        ci_q <= 2'd0;
        if (j_q == '0 && r_next == '0) begin
          zero_q <= 1'b1;
        end
      end
      N_DLOAD: begin
        rem_q  <= (CMP_W'(mag_q[ci_q][A_W-1:0]) << (UNIT_WIDTH - 1)) +
                  CMP_W'(r_q[LEN_W-1:0]);
        q_q    <= '0;
        qj_q   <= Q_J_W'(Q_W - 1);
        zero_q <= 1'b0;
      end
      N_DIV: begin
        if (div_ge) begin
          rem_q <= rem_q - dsh;
        end
        q_q  <= q_new;
        qj_q <= qj_q - 1'b1;
        if (qj_q == '0) begin
          unit_q[ci_q] <= neg_q[ci_q] ? -$signed(q_new) : $signed(q_new);
          ci_q         <= ci_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign zero_o = zero_q;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_o[i] = unit_q[i];
    end
  end

endmodule

### hdl/tntf_back.sv
// ----------------------------------------------------------------------------
// tntf_back
// Face sequencer: cross products and the UV determinant on one shared multiplier, then normalizing.
// ----------------------------------------------------------------------------
module tntf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tntf_pkg::job_t      job_i,
  input  logic                job_empty_i,
  output logic                job_pop_o,
  input  logic                pop_i,
  output logic                res_valid_o,
  output tntf_pkg::out_item_t res_o
);
  import tntf_pkg::*;

  back_state_e  state_q, state_d;
  pass_e        pass_q;
  logic [2:0]   k_q, last_k;
  logic         ph_q, det_neg_q, fb_q, tv_q, res_valid_q, res_load;
  job_t         job_q;
  vec_t         c_q [3];
  vec_t [2:0]   nvec;
  prod_t        prod_q, tmp_q, prod_d;
  diff_t        a_op, b_op;
  vec_t         diff_v;
  unit_t        nrm_q [3], tan_q [3], bit_q [3];
  unit_t [2:0]  n_unit;
  logic         n_start, n_done, n_zero;
  out_item_t    res_q;

  // Component order for a cross product a x b, two products per component.
  function automatic logic [1:0] a_idx(input logic [2:0] k);
    case (k)
      3'd0:    a_idx = 2'd1;
      3'd1:    a_idx = 2'd2;
      3'd2:    a_idx = 2'd2;
      3'd3:    a_idx = 2'd0;
      3'd4:    a_idx = 2'd0;
      default: a_idx = 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] b_idx(input logic [2:0] k);
    case (k)
      3'd0:    b_idx = 2'd2;
      3'd1:    b_idx = 2'd1;
      3'd2:    b_idx = 2'd0;
      3'd3:    b_idx = 2'd2;
      3'd4:    b_idx = 2'd1;
      default: b_idx = 2'd0;
    endcase
  endfunction

  always_comb begin
    case (pass_q)
      P_FACE: begin
        a_op = $signed(job_q.e1[a_idx(k_q)]);
        b_op = $signed(job_q.e2n[b_idx(k_q)]);
      end
      P_DET: begin
        a_op = k_q[0] ? $signed(job_q.du2) : $signed(job_q.du1);
        b_op = k_q[0] ? $signed(job_q.dv1) : $signed(job_q.dv2);
      end
      P_TAN: begin
        a_op = k_q[0] ? $signed(job_q.dv1) : $signed(job_q.dv2);
        b_op = k_q[0] ? $signed(job_q.e2t[k_q[2:1]]) : $signed(job_q.e1[k_q[2:1]]);
      end
      default: begin
        a_op = DIFF_W'(nrm_q[a_idx(k_q)]);
        b_op = DIFF_W'(tan_q[b_idx(k_q)]);
      end
    endcase
  end

  assign prod_d = a_op * b_op;
  assign last_k = (pass_q == P_DET) ? 3'd1 : 3'd5;

  // A negative determinant flips the tangent direction.
  assign diff_v = (pass_q == P_TAN && det_neg_q) ? VEC_W'(prod_q) - VEC_W'(tmp_q)
                                                 : VEC_W'(tmp_q) - VEC_W'(prod_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nvec[i] = c_q[i];
    end
  end

  assign n_start   = (state_q == B_NSTART);
  assign job_pop_o = (state_q == B_IDLE) && !job_empty_i;
  assign res_load  = (state_q == B_OUT) && (!res_valid_q || pop_i);

  tntf_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (n_start),
    .vec_i   (nvec),
    .done_o  (n_done),
    .zero_o  (n_zero),
    .unit_o  (n_unit)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!job_empty_i) state_d = B_MUL;
      B_MUL: begin
        if (ph_q && k_q == last_k) begin
          state_d = (pass_q == P_DET) ? B_DCHK : B_NSTART;
        end
      end
      B_NSTART: state_d = B_NWAIT;
      B_NWAIT: begin
        if (n_done) begin
          if (pass_q == P_FACE) begin
            state_d = B_MUL;
          end else if (pass_q == P_TAN && !n_zero) begin
            state_d = B_MUL;
          end else begin
            state_d = B_OUT;
          end
        end
      end
      B_DCHK:  state_d = (c_q[0] == '0) ? B_OUT : B_MUL;
      B_OUT:   if (res_load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      pass_q      <= P_FACE;
      k_q         <= 3'd0;
      ph_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          pass_q <= P_FACE;
          k_q    <= 3'd0;
          ph_q   <= 1'b0;
        end
        B_MUL: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            k_q <= (k_q == last_k) ? 3'd0 : k_q + 3'd1;
          end
        end
        B_NWAIT: begin
          if (n_done) begin
            if (pass_q == P_FACE) begin
              pass_q <= P_DET;
            end else if (pass_q == P_TAN) begin
              pass_q <= P_BIT;
            end
          end
        end
        B_DCHK:  pass_q <= P_TAN;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        job_q <= job_i;
      end
      B_MUL: begin
        if (!ph_q) begin
          prod_q <= prod_d;
        end else if (!k_q[0]) begin
          tmp_q <= prod_q;
        end else begin
          c_q[k_q[2:1]] <= diff_v;
        end
      end
      B_NWAIT: begin
        if (n_done) begin
          case (pass_q)
            P_FACE: begin
              fb_q <= n_zero;
              for (int i = 0; i < 3; i++) begin
                nrm_q[i] <= n_zero ? $signed(job_q.vn[i]) : $signed(n_unit[i]);
              end
            end
            P_TAN: begin
              tv_q <= !n_zero;
              for (int i = 0; i < 3; i++) begin
                tan_q[i] <= n_zero ? '0 : $signed(n_unit[i]);
                bit_q[i] <= '0;
              end
            end
            default: begin
              for (int i = 0; i < 3; i++) begin
                bit_q[i] <= n_zero ? '0 : $signed(n_unit[i]);
              end
            end
          endcase
        end
      end
      B_DCHK: begin
        det_neg_q <= c_q[0][VEC_W-1];
        if (c_q[0] == '0) begin
          tv_q <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            tan_q[i] <= '0;
            bit_q[i] <= '0;
          end
        end
      end
      B_OUT: begin
        if (res_load) begin
          res_q.normal_x        <= nrm_q[0];
          res_q.normal_y        <= nrm_q[1];
          res_q.normal_z        <= nrm_q[2];
          res_q.tangent_x       <= tan_q[0];
          res_q.tangent_y       <= tan_q[1];
          res_q.tangent_z       <= tan_q[2];
          res_q.bitangent_x     <= bit_q[0];
          res_q.bitangent_y     <= bit_q[1];
          res_q.bitangent_z     <= bit_q[2];
          res_q.normal_fallback <= fb_q;
          res_q.tangent_valid   <= tv_q;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### verif/triangle_normal_tangent_frame_unit_checker.sv
// ----------------------------------------------------------------------------
// triangle_normal_tangent_frame_unit_checker
// Watches both queue ports of the frame unit, predicts every face and compares.
// ----------------------------------------------------------------------------
// Each accepted corner goes through a bit-exact model of the face frame math.
// Every third corner queues one expected item, and each popped item is checked
// field by field against the oldest one. Leftovers are flagged on done_i.
module triangle_normal_tangent_frame_unit_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  tntf_pkg::in_item_t  in_item_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  tntf_pkg::out_item_t out_item_i,
  input  logic                done_i,
  output int                  pending_o,
  output int                  fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tntf_pkg::*;

  localparam longint unsigned UNIT_ONE = 64'd1 << (UNIT_WIDTH - 2);

  typedef logic signed [127:0] wide_t;

  out_item_t face_q[$];
  int        corner_idx;
  longint    held_pos[2][3];
  longint    held_uv[2][2];
  longint    held_vn[3];
  bit        leftover_done;

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic wide_t xmul(input longint a, b, c, d);
    wide_t wa, wb, wc, wd;
    wa = a; wb = b; wc = c; wd = d;
    return wa * wb - wc * wd;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scales a vector to unit length in Q2.14; returns 0 for the zero vector.
  function automatic bit unit_scale(input wide_t c0, c1, c2, output longint q[3]);
    wide_t           cv[3];
    logic [127:0]    m[3];
    longint unsigned a[3];
    longint unsigned sum, len, quo;
    int              maxbits, sh;
    cv = '{c0, c1, c2};
    maxbits = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (cv[i] < 0) ? -cv[i] : cv[i];
      for (int b = 0; b < 128; b++) if (m[i][b] && b + 1 > maxbits) maxbits = b + 1;
    end
    sh = (maxbits > 30) ? maxbits - 30 : 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = 64'(m[i] >> sh);
      sum += a[i] * a[i];
    end
    len = int_sqrt(sum);
    q = '{0, 0, 0};
    if (len == 0) return 0;
    for (int i = 0; i < 3; i++) begin
      quo = (2 * a[i] * UNIT_ONE + len) / (2 * len);
      q[i] = (cv[i] < 0) ? -longint'(quo) : longint'(quo);
    end
    return 1;
  endfunction

  function automatic out_item_t face_frame(input longint p[3], input longint u, v);
    longint    e1[3], e2n[3], e2t[3], nrm[3], tng[3], btg[3];
    longint    du1, dv1, du2, dv2, b0, b1, b2;
    wide_t     det, t[3];
    bit        fallback, tvalid;
    out_item_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i]  = held_pos[1][i] - held_pos[0][i];
      e2n[i] = p[i] - held_pos[0][i];
      e2t[i] = p[i] - held_pos[1][i];
    end
    fallback = !unit_scale(xmul(e1[1], e2n[2], e1[2], e2n[1]),
                           xmul(e1[2], e2n[0], e1[0], e2n[2]),
                           xmul(e1[0], e2n[1], e1[1], e2n[0]), nrm);
    if (fallback) nrm = held_vn;
    du1 = held_uv[1][0] - held_uv[0][0];
    dv1 = held_uv[0][1] - held_uv[1][1];
    du2 = u - held_uv[1][0];
    dv2 = held_uv[1][1] - v;
    det = xmul(du1, dv2, du2, dv1);
    tng = '{0, 0, 0};
    btg = '{0, 0, 0};
    tvalid = 0;
    if (det != 0) begin
      for (int i = 0; i < 3; i++) begin
        t[i] = xmul(dv2, e1[i], dv1, e2t[i]);
        if (det < 0) t[i] = -t[i];
      end
      tvalid = unit_scale(t[0], t[1], t[2], tng);
      if (tvalid) begin
        b0 = nrm[1] * tng[2] - nrm[2] * tng[1];
        b1 = nrm[2] * tng[0] - nrm[0] * tng[2];
        b2 = nrm[0] * tng[1] - nrm[1] * tng[0];
        if (!unit_scale(b0, b1, b2, btg)) btg = '{0, 0, 0};
      end
    end
    r.normal_x        = unit_t'(nrm[0]);
    r.normal_y        = unit_t'(nrm[1]);
    r.normal_z        = unit_t'(nrm[2]);
    r.tangent_x       = unit_t'(tng[0]);
    r.tangent_y       = unit_t'(tng[1]);
    r.tangent_z       = unit_t'(tng[2]);
    r.bitangent_x     = unit_t'(btg[0]);
    r.bitangent_y     = unit_t'(btg[1]);
    r.bitangent_z     = unit_t'(btg[2]);
    r.normal_fallback = fallback;
    r.tangent_valid   = tvalid;
    return r;
  endfunction

  task automatic take_corner(input in_item_t c);
    longint p[3];
    p = '{c.pos_x, c.pos_y, c.pos_z};
    if (corner_idx < 2) begin
      held_pos[corner_idx] = p;
      held_uv[corner_idx]  = '{c.tex_u, c.tex_v};
      if (corner_idx == 0) held_vn = '{c.vnorm_x, c.vnorm_y, c.vnorm_z};
      corner_idx++;
    end else begin
      corner_idx = 0;
      face_q = {face_q, face_frame(p, c.tex_u, c.tex_v)};
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic check_face(input out_item_t got);
    out_item_t want;
    if (face_q.size() == 0) begin
      report("result item with no face pending");
      return;
    end
    want = face_q.pop_front();
    check_field("normal_x", got.normal_x, want.normal_x);
    check_field("normal_y", got.normal_y, want.normal_y);
    check_field("normal_z", got.normal_z, want.normal_z);
    check_field("tangent_x", got.tangent_x, want.tangent_x);
    check_field("tangent_y", got.tangent_y, want.tangent_y);
    check_field("tangent_z", got.tangent_z, want.tangent_z);
    check_field("bitangent_x", got.bitangent_x, want.bitangent_x);
    check_field("bitangent_y", got.bitangent_y, want.bitangent_y);
    check_field("bitangent_z", got.bitangent_z, want.bitangent_z);
    check_field("normal_fallback", got.normal_fallback, want.normal_fallback);
    check_field("tangent_valid", got.tangent_valid, want.tangent_valid);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_idx    = 0;
      leftover_done = 0;
      face_q.delete();
      pending_o     = 0;
    end else begin
      if (pop_i && !empty_i) check_face(out_item_i);
      if (push_i && !full_i) take_corner(in_item_i);
      if (done_i && !leftover_done) begin
        leftover_done = 1;
        if (face_q.size() != 0) report($sformatf("%0d faces never came out", face_q.size()));
      end
      pending_o = face_q.size();
    end
  end

endmodule

### verif/triangle_normal_tangent_frame_unit_test.sv
// ----------------------------------------------------------------------------
// triangle_normal_tangent_frame_unit_test
// Stimulus and verdict for the triangle normal and tangent frame unit.
// ----------------------------------------------------------------------------
// Directed faces cover coordinate extremes, degenerate faces, zero and negative
// UV determinants and a normal parallel to the tangent; random faces follow.
// Both sides idle at random and the receiver stalls once to fill the unit.
module triangle_normal_tangent_frame_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tntf_pkg::*;

  localparam int      RANDOM_CORNERS = 828;
  localparam longint  CYCLE_LIMIT    = 1000000;
  localparam int      DRAIN_CYCLES   = 600;
  localparam int      Q1             = 32'h0001_0000;
  localparam shortint UNIT           = 16384;

  logic      clk, rst_n, push, full, empty, pop, done;
  in_item_t  corner;
  out_item_t face;
  int        fail_count, pending, faces_seen;
  longint    cycles;
  logic      corner_taken;
  bit        calm;

  triangle_normal_tangent_frame_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full), .in_item_i(corner),
    .empty(empty), .pop(pop), .out_item_o(face)
  );

  triangle_normal_tangent_frame_unit_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_i(full), .in_item_i(corner),
    .empty_i(empty), .pop_i(pop), .out_item_i(face), .done_i(done),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles       <= cycles + 1;
    corner_taken <= push && !full;
    if (pop && !empty) faces_seen <= faces_seen + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_item_t mk(input int x, y, z, u, v,
                                  input shortint nx = 0, ny = 0, nz = 0);
    in_item_t c;
    c = '{pos_x: x, pos_y: y, pos_z: z, tex_u: u, tex_v: v,
          vnorm_x: nx, vnorm_y: ny, vnorm_z: nz};
    return c;
  endfunction

  function automatic int rand_coord();
    int k;
    k = $urandom_range(99);
    if (k < 65) return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    if (k < 85) return $urandom;
    return $signed($urandom_range(6)) - 3;
  endfunction

  function automatic in_item_t rand_corner();
    in_item_t c;
    c = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           16'($urandom), 16'($urandom), 16'($urandom));
    return c;
  endfunction

  // Holds the corner until the unit takes it; the next drive lands on the
  // falling edge right after the accepting rising edge.
  task automatic send(input in_item_t c);
    int gap;
    if (!calm && $urandom_range(99) < 18) begin
      gap = $urandom_range(1, 5);
      push <= 0;
      repeat (gap) @(negedge clk);
    end
    push   <= 1;
    corner <= c;
    do @(negedge clk); while (!corner_taken);
  endtask

  // Receiver side: random pops, one long hold-off after the first few faces.
  initial begin
    bit held;
    held = 0;
    pop  = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && faces_seen >= 5) begin
        held = 1;
        pop <= 0;
        repeat (3000) @(negedge clk);
      end
      pop <= calm || ($urandom_range(99) >= 18);
    end
  end

  initial begin
    in_item_t c;
    calm         = 0;
    done         = 0;
    push         = 0;
    corner       = '0;
    rst_n        = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Plain unit face.
    send(mk(0, 0, 0, 0, 0, 0, 0, UNIT));
    send(mk(Q1, 0, 0, Q1, 0));
    send(mk(0, Q1, 0, 0, Q1));
    // Coordinate extremes, with a positive determinant.
    send(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            16'sh7fff, 16'sh8000, 16'sh7fff));
    send(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    send(mk(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000));
    // All corners equal: fallback normal, no tangent.
    send(mk(5, 5, 5, 1, 2, 16'sh8000, 16'sh7fff, 0));
    send(mk(5, 5, 5, 3, 4));
    send(mk(5, 5, 5, 9, 1));
    // Degenerate with a zero fallback normal: bitangent zero, tangent valid.
    send(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(0, Q1, 0, Q1, 0));
    send(mk(0, 2 * Q1, 0, Q1, Q1));
    // Zero determinant.
    send(mk(0, 0, 0, 7, 7, 0, UNIT, 0));
    send(mk(Q1, 0, 0, 7, 7));
    send(mk(0, 0, Q1, 7, 7));
    // Normal parallel to tangent through the fallback.
    send(mk(0, 0, 0, 0, 0, UNIT, 0, 0));
    send(mk(Q1, 0, 0, Q1, 0));
    send(mk(2 * Q1, 0, 0, Q1, Q1));
    // Swapped texture winding.
    send(mk(0, 0, 0, 0, 0, -UNIT, 0, 0));
    send(mk(Q1, 0, 0, 0, Q1));
    send(mk(0, Q1, 0, Q1, 0));
    // Nonzero determinant but zero tangent direction.
    send(mk(3, 3, 3, 0, 0, 1, 1, 1));
    send(mk(3, 3, 3, Q1, 0));
    send(mk(3, 3, 3, 0, Q1));

    for (int i = 0; i < RANDOM_CORNERS; i++) begin
      calm = (i >= 300 && i < 420);
      if ($urandom_range(9) == 0 && i % 3 == 2) begin
        // Third corner with all three position coordinates equal.
        c = rand_corner();
        c.pos_x = c.pos_y;
        c.pos_z = c.pos_y;
        send(c);
      end else begin
        send(rand_corner());
      end
    end
    calm = 0;
    push <= 0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    done <= 1;
    repeat (2) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
